// ===== src/aessb_pkg.sv =====
package aessb_pkg;

    // One state byte, and the sixteen bytes of a full state as lanes.
    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned HALF_W     = 64;
    localparam int unsigned HALF_BYTES = HALF_W / BYTE_W;
    localparam int unsigned NUM_LANES  = 2 * HALF_BYTES;

    typedef logic [BYTE_W-1:0] byte_t;
    typedef logic [HALF_W-1:0] half_t;
    typedef byte_t lanes_t [NUM_LANES];

endpackage

// ===== src/aessb_in_if.sv =====
interface aessb_in_if;
    import aessb_pkg::*;

    logic  valid;
    logic  ready;
    half_t state_low;
    half_t state_high;

    modport source (output valid, output state_low, output state_high, input ready);
    modport sink   (input valid, input state_low, input state_high, output ready);
endinterface

// ===== src/aessb_out_if.sv =====
interface aessb_out_if;
    import aessb_pkg::*;

    logic  valid;
    logic  ready;
    half_t sub_low;
    half_t sub_high;

    modport source (output valid, output sub_low, output sub_high, input ready);
    modport sink   (input valid, input sub_low, input sub_high, output ready);
endinterface

// ===== src/aessb_lane.sv =====
// One AES S-box as the Boyar-Peralta gate network: a linear top layer, a
// shared GF(2^4) inversion core and a linear bottom layer.
module aessb_lane
    import aessb_pkg::*;
(
    input  byte_t x,
    output byte_t y
);

    logic u0, u1, u2, u3, u4, u5, u6, u7;
    logic l1, l2, l3, l4, l5, l6, l7, l8, l9, l10, l11, l12, l13, l14, l15;
    logic l16, l17, l18, l19, l20, l21;
    logic g0, g1, g2, g3, g4, g5, g6, g7, g8, g9, g10, g11, g12, g13, g14, g15;
    logic g16, g17, g18, g19, g20, g21, g22, g23, g24, g25, g26, g27, g28, g29;
    logic g30, g31, g32, g33, g34, g35, g36, g37, g38, g39, g40, g41, g42, g43;
    logic g44, g45;
    logic m0, m1, m2, m3, m4, m5, m6, m7, m8, m9, m10, m11, m12, m13, m14, m15;
    logic m16, m17;
    logic c1, c2, c3, c4, c5, c6, c7, c8, c9, c10, c11, c12, c13, c14;
    logic c16, c17, c18, c20, c21, c26;
    logic s0, s1, s2, s3, s4, s5, s6, s7;

    // Bit 7 of the byte is circuit input U0.
    assign {u0, u1, u2, u3, u4, u5, u6, u7} = x;

    // Top linear layer.
    assign l14 = u3 ^ u5;
    assign l13 = u0 ^ u6;
    assign l9  = u0 ^ u3;
    assign l8  = u0 ^ u5;
    assign g0  = u1 ^ u2;
    assign l1  = g0 ^ u7;
    assign l4  = l1 ^ u3;
    assign l12 = l13 ^ l14;
    assign l2  = l1 ^ u0;
    assign l5  = l1 ^ u6;
    assign l3  = l5 ^ l8;
    assign g1  = u4 ^ l12;
    assign l15 = g1 ^ u5;
    assign l20 = g1 ^ u1;
    assign l6  = l15 ^ u7;
    assign l10 = l15 ^ g0;
    assign l11 = l20 ^ l9;
    assign l7  = u7 ^ l11;
    assign l17 = l10 ^ l11;
    assign l19 = l10 ^ l8;
    assign l16 = g0 ^ l11;
    assign l21 = l13 ^ l16;
    assign l18 = u0 ^ l16;

    // Nonlinear core.
    assign g2  = l12 & l15;
    assign g3  = l3 & l6;
    assign g4  = g3 ^ g2;
    assign g5  = l4 & u7;
    assign g6  = g5 ^ g2;
    assign g7  = l13 & l16;
    assign g8  = l5 & l1;
    assign g9  = g8 ^ g7;
    assign g10 = l2 & l7;
    assign g11 = g10 ^ g7;
    assign g12 = l9 & l11;
    assign g13 = l14 & l17;
    assign g14 = g13 ^ g12;
    assign g15 = l8 & l10;
    assign g16 = g15 ^ g12;
    assign g17 = g4 ^ l20;
    assign g18 = g6 ^ g16;
    assign g19 = g9 ^ g14;
    assign g20 = g11 ^ g16;
    assign g21 = g17 ^ g14;
    assign g22 = g18 ^ l19;
    assign g23 = g19 ^ l21;
    assign g24 = g20 ^ l18;
    assign g25 = g21 ^ g22;
    assign g26 = g21 & g23;
    assign g27 = g24 ^ g26;
    assign g28 = g25 & g27;
    assign g29 = g28 ^ g22;
    assign g30 = g23 ^ g24;
    assign g31 = g22 ^ g26;
    assign g32 = g31 & g30;
    assign g33 = g32 ^ g24;
    assign g34 = g23 ^ g33;
    assign g35 = g27 ^ g33;
    assign g36 = g24 & g35;
    assign g37 = g36 ^ g34;
    assign g38 = g27 ^ g36;
    assign g39 = g29 & g38;
    assign g40 = g25 ^ g39;
    assign g41 = g40 ^ g37;
    assign g42 = g29 ^ g33;
    assign g43 = g29 ^ g40;
    assign g44 = g33 ^ g37;
    assign g45 = g42 ^ g41;

    assign m0  = g44 & l15;
    assign m1  = g37 & l6;
    assign m2  = g33 & u7;
    assign m3  = g43 & l16;
    assign m4  = g40 & l1;
    assign m5  = g29 & l7;
    assign m6  = g42 & l11;
    assign m7  = g45 & l17;
    assign m8  = g41 & l10;
    assign m9  = g44 & l12;
    assign m10 = g37 & l3;
    assign m11 = g33 & l4;
    assign m12 = g43 & l13;
    assign m13 = g40 & l5;
    assign m14 = g29 & l2;
    assign m15 = g42 & l9;
    assign m16 = g45 & l14;
    assign m17 = g41 & l8;

    // Bottom linear layer; four outputs come out inverted.
    assign c1  = m15 ^ m16;
    assign c2  = m10 ^ c1;
    assign c3  = m9 ^ c2;
    assign c4  = m0 ^ m2;
    assign c5  = m1 ^ m0;
    assign c6  = m3 ^ m4;
    assign c7  = m12 ^ c4;
    assign c8  = m7 ^ c6;
    assign c9  = m8 ^ c7;
    assign c10 = c8 ^ c9;
    assign c11 = c6 ^ c5;
    assign c12 = m3 ^ m5;
    assign c13 = m13 ^ c1;
    assign c14 = c4 ^ c12;
    assign s3  = c3 ^ c11;
    assign c16 = m6 ^ c8;
    assign c17 = m14 ^ c10;
    assign c18 = c13 ^ c14;
    assign s7  = ~(m12 ^ c18);
    assign c20 = m15 ^ c16;
    assign c21 = c2 ^ m11;
    assign s0  = c3 ^ c16;
    assign s6  = ~(c10 ^ c18);
    assign s4  = c14 ^ s3;
    assign s1  = ~(s3 ^ c16);
    assign c26 = c17 ^ c20;
    assign s2  = ~(c26 ^ m17);
    assign s5  = c21 ^ c17;

    // Output S0 goes to bit 7.
    assign y = {s0, s1, s2, s3, s4, s5, s6, s7};

endmodule

// ===== src/aessb_merge.sv =====
// Gathers the sixteen lane results into the two output halves and holds
// them in an output register backed by a skid register, so that one item
// can be taken while the previous result waits on the output.
module aessb_merge
    import aessb_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                lanes_valid,
    output logic                lanes_ready,
    input  lanes_t              lanes,
    aessb_out_if.source         sub
);

    half_t merged_low;
    half_t merged_high;
    logic  accept;
    logic  pop;
    logic  load_out;

    logic  out_valid_reg, out_valid_next;
    half_t out_low_reg, out_low_next;
    half_t out_high_reg, out_high_next;
    logic  skid_valid_reg, skid_valid_next;
    half_t skid_low_reg, skid_low_next;
    half_t skid_high_reg, skid_high_next;

    always_comb
    begin
        for (int k = 0; k < int'(HALF_BYTES); k++)
        begin
            merged_low[k*BYTE_W +: BYTE_W]  = lanes[k];
            merged_high[k*BYTE_W +: BYTE_W] = lanes[k + int'(HALF_BYTES)];
        end
    end

    assign lanes_ready = ~skid_valid_reg;
    assign accept      = lanes_valid & lanes_ready;
    assign pop         = out_valid_reg & sub.ready;
    assign load_out    = ~out_valid_reg | pop;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_low_next    = out_low_reg;
        out_high_next   = out_high_reg;
        skid_valid_next = skid_valid_reg;
        skid_low_next   = skid_low_reg;
        skid_high_next  = skid_high_reg;
        if (load_out)
        begin
            if (skid_valid_reg)
            begin
                out_low_next  = skid_low_reg;
                out_high_next = skid_high_reg;
            end
            else
            begin
                out_low_next  = merged_low;
                out_high_next = merged_high;
            end
            out_valid_next  = skid_valid_reg | accept;
            skid_valid_next = 1'b0;
        end
        else if (accept)
        begin
            skid_valid_next = 1'b1;
            skid_low_next   = merged_low;
            skid_high_next  = merged_high;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_low_reg   <= out_low_next;
        out_high_reg  <= out_high_next;
        skid_low_reg  <= skid_low_next;
        skid_high_reg <= skid_high_next;
    end

    assign sub.valid    = out_valid_reg;
    assign sub.sub_low  = out_low_reg;
    assign sub.sub_high = out_high_reg;

`ifndef SYNTH
    // The skid register only fills behind a waiting output result.
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid register holds an item with the output empty");

    // An item taken while the output stalls lands in the skid register.
    a_stall_to_skid: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && out_valid_reg && !sub.ready) |=> skid_valid_reg)
        else $error("item taken during an output stall was dropped");

    // A drained skid entry becomes the next output result.
    a_skid_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_valid_reg && sub.ready) |=>
            (out_valid_reg && out_low_reg == $past(skid_low_reg)
             && out_high_reg == $past(skid_high_reg)))
        else $error("skid entry lost on drain");

    // With no backlog, a taken item is on the output in the next cycle.
    a_direct_load: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && load_out) |=>
            (out_valid_reg && out_low_reg == $past(merged_low)
             && out_high_reg == $past(merged_high)))
        else $error("item not loaded into the output register");
`endif

endmodule

// ===== src/aes_subbytes_state_top.sv =====
// Channel   Role     Payload                     Handshake
// state_ch  sink     state_low, state_high (64)  valid / ready
// sub_ch    source   sub_low, sub_high (64)      valid / ready
//
// Each item is substituted on the way in and its result registered in the
// output register, or in the skid register while sub_ch stalls. One item per
// cycle is sustained while sub_ch is ready, set by the sixteen S-box lanes.
// Reset clears only the valid flags of the output and skid registers.
// A stalled output keeps one more item in the skid register; state_ch.ready
// falls only while that register is full.
//
// The state is split into sixteen bytes. Byte k of the state is lane k:
// bytes 0 to 7 come from state_low, bytes 8 to 15 from state_high, byte 0
// and byte 8 in the low bits of their halves. Every lane is a copy of the
// Boyar-Peralta S-box network, and the merge stage packs the lane results
// back into two halves with the same byte order before registering them.
module aes_subbytes_state_top
    import aessb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    aessb_in_if.sink    state_ch,
    aessb_out_if.source sub_ch
);

    lanes_t lane_in;
    lanes_t lane_out;

    // Split both halves into per-byte lanes.
    always_comb
    begin
        for (int k = 0; k < int'(HALF_BYTES); k++)
        begin
            lane_in[k]                   = state_ch.state_low[k*BYTE_W +: BYTE_W];
            lane_in[k + int'(HALF_BYTES)] = state_ch.state_high[k*BYTE_W +: BYTE_W];
        end
    end

    // Sixteen S-box lanes work on the bytes of the item side by side.
    for (genvar g = 0; g < NUM_LANES; g++)
    begin : g_lane
        aessb_lane u_lane (
            .x (lane_in[g]),
            .y (lane_out[g])
        );
    end

    // Merge and register; the skid register keeps the input side moving.
    aessb_merge u_merge (
        .clk         (clk),
        .rst_n       (rst_n),
        .lanes_valid (state_ch.valid),
        .lanes_ready (state_ch.ready),
        .lanes       (lane_out),
        .sub         (sub_ch)
    );

endmodule

// ===== bench/tb_top.sv =====
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import aessb_pkg::*;

    // Number of random items after the directed part, and how many items at
    // the end of the run are sent with no idling on either side.
    localparam int RANDOM_ITEMS = 1528;
    localparam int CALM_TAIL    = 300;
    // Receiver hold-off, long enough to fill the output and skid registers.
    localparam int HOLD_CYCLES  = 60;
    localparam int DRAIN_LIMIT  = 2000;

    // Scoreboard: turns each accepted state into its expected SubBytes image
    // and compares the results in order of arrival.
    class subbytes_board;
        typedef struct packed {
            half_t low;
            half_t high;
        } sub_pair_t;

        sub_pair_t sub_pairs_due[$];
        int        errors;

        // Substitutes all eight bytes of a half at once. Each byte is a lane,
        // and bit k of a lane is taken out to the lowest bit of that byte, so
        // that plain word-wide XOR and AND run the S-box gate network on all
        // lanes in parallel. Byte bit 7 is the first circuit input, and the
        // first circuit output goes back to byte bit 7.
        static function half_t sub_half(half_t w);
            half_t lsb, x0, x1, x2, x3, x4, x5, x6, x7;
            half_t t1, t2, t3, t4, t5, t6, t7, t8, t9, t10, t11, t12, t13, t14;
            half_t t15, t16, t17, t18, t19, t20, t21;
            half_t n0, n1, n2, n3, n4, n5, n6, n7, n8, n9, n10, n11, n12, n13;
            half_t n14, n15, n16, n17, n18, n19, n20, n21, n22, n23, n24, n25;
            half_t n26, n27, n28, n29, n30, n31, n32, n33, n34, n35, n36, n37;
            half_t n38, n39, n40, n41, n42, n43, n44, n45;
            half_t p0, p1, p2, p3, p4, p5, p6, p7, p8, p9, p10, p11, p12, p13;
            half_t p14, p15, p16, p17;
            half_t b1, b2, b3, b4, b5, b6, b7, b8, b9, b10, b11, b12, b13, b14;
            half_t b16, b17, b18, b20, b21, b26;
            half_t o0, o1, o2, o3, o4, o5, o6, o7;

            lsb = {HALF_BYTES{8'h01}};
            x0 = (w >> 7) & lsb;
            x1 = (w >> 6) & lsb;
            x2 = (w >> 5) & lsb;
            x3 = (w >> 4) & lsb;
            x4 = (w >> 3) & lsb;
            x5 = (w >> 2) & lsb;
            x6 = (w >> 1) & lsb;
            x7 = w & lsb;

            // Linear input layer.
            t14 = x3 ^ x5;   t13 = x0 ^ x6;   t9 = x0 ^ x3;    t8 = x0 ^ x5;
            n0  = x1 ^ x2;
            t1  = n0 ^ x7;   t4  = t1 ^ x3;   t12 = t13 ^ t14;
            t2  = t1 ^ x0;   t5  = t1 ^ x6;   t3  = t5 ^ t8;
            n1  = x4 ^ t12;
            t15 = n1 ^ x5;   t20 = n1 ^ x1;
            t6  = t15 ^ x7;  t10 = t15 ^ n0;  t11 = t20 ^ t9;
            t7  = x7 ^ t11;  t17 = t10 ^ t11; t19 = t10 ^ t8;
            t16 = n0 ^ t11;  t21 = t13 ^ t16; t18 = x0 ^ t16;

            // Shared inversion core in GF(2^4).
            n2  = t12 & t15; n3  = t3 & t6;   n4  = n3 ^ n2;
            n5  = t4 & x7;   n6  = n5 ^ n2;
            n7  = t13 & t16; n8  = t5 & t1;   n9  = n8 ^ n7;
            n10 = t2 & t7;   n11 = n10 ^ n7;
            n12 = t9 & t11;  n13 = t14 & t17; n14 = n13 ^ n12;
            n15 = t8 & t10;  n16 = n15 ^ n12;
            n17 = n4 ^ t20;  n18 = n6 ^ n16;  n19 = n9 ^ n14;
            n20 = n11 ^ n16; n21 = n17 ^ n14; n22 = n18 ^ t19;
            n23 = n19 ^ t21; n24 = n20 ^ t18;
            n25 = n21 ^ n22; n26 = n21 & n23; n27 = n24 ^ n26;
            n28 = n25 & n27; n29 = n28 ^ n22; n30 = n23 ^ n24;
            n31 = n22 ^ n26; n32 = n31 & n30; n33 = n32 ^ n24;
            n34 = n23 ^ n33; n35 = n27 ^ n33; n36 = n24 & n35;
            n37 = n36 ^ n34; n38 = n27 ^ n36; n39 = n29 & n38;
            n40 = n25 ^ n39; n41 = n40 ^ n37; n42 = n29 ^ n33;
            n43 = n29 ^ n40; n44 = n33 ^ n37; n45 = n42 ^ n41;

            p0  = n44 & t15; p1  = n37 & t6;  p2  = n33 & x7;
            p3  = n43 & t16; p4  = n40 & t1;  p5  = n29 & t7;
            p6  = n42 & t11; p7  = n45 & t17; p8  = n41 & t10;
            p9  = n44 & t12; p10 = n37 & t3;  p11 = n33 & t4;
            p12 = n43 & t13; p13 = n40 & t5;  p14 = n29 & t2;
            p15 = n42 & t9;  p16 = n45 & t14; p17 = n41 & t8;

            // Linear output layer; four outputs are inverted.
            b1  = p15 ^ p16; b2  = p10 ^ b1;  b3  = p9 ^ b2;
            b4  = p0 ^ p2;   b5  = p1 ^ p0;   b6  = p3 ^ p4;
            b7  = p12 ^ b4;  b8  = p7 ^ b6;   b9  = p8 ^ b7;
            b10 = b8 ^ b9;   b11 = b6 ^ b5;   b12 = p3 ^ p5;
            b13 = p13 ^ b1;  b14 = b4 ^ b12;
            o3  = b3 ^ b11;
            b16 = p6 ^ b8;   b17 = p14 ^ b10; b18 = b13 ^ b14;
            o7  = p12 ^ b18 ^ lsb;
            b20 = p15 ^ b16; b21 = b2 ^ p11;
            o0  = b3 ^ b16;
            o6  = b10 ^ b18 ^ lsb;
            o4  = b14 ^ o3;
            o1  = o3 ^ b16 ^ lsb;
            b26 = b17 ^ b20;
            o2  = b26 ^ p17 ^ lsb;
            o5  = b21 ^ b17;

            return (o0 << 7) | (o1 << 6) | (o2 << 5) | (o3 << 4) |
                   (o4 << 3) | (o5 << 2) | (o6 << 1) | o7;
        endfunction

        function void note_state(half_t state_low, half_t state_high);
            sub_pair_t due;
            due.low  = sub_half(state_low);
            due.high = sub_half(state_high);
            sub_pairs_due.push_back(due);
        endfunction

        function void check_sub(half_t sub_low, half_t sub_high);
            sub_pair_t due;
            if (sub_pairs_due.size() == 0)
            begin
                $display("%0t: unexpected result, got sub_low %h sub_high %h",
                         $time, sub_low, sub_high);
                errors++;
                return;
            end
            due = sub_pairs_due.pop_front();
            if (sub_low !== due.low)
            begin
                $display("%0t: sub_low mismatch, expected %h, got %h",
                         $time, due.low, sub_low);
                errors++;
            end
            if (sub_high !== due.high)
            begin
                $display("%0t: sub_high mismatch, expected %h, got %h",
                         $time, due.high, sub_high);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;

    aessb_in_if  state_ch();
    aessb_out_if sub_ch();

    aes_subbytes_state_top dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .state_ch (state_ch),
        .sub_ch   (sub_ch)
    );

    subbytes_board board = new();

    // Idling switches. The sender and the receiver each read their own flag;
    // the main sequence turns them on and off in segments of the run and asks
    // the receiver for one long hold-off in the middle of it.
    bit send_gaps;
    bit sink_stalls;
    bit hold_request;

    initial
    begin
        clk = 1'b0;
    end

    always #4 clk = ~clk;

    // Runaway guard: the slowest correct run stays well below this.
    initial
    begin
        #2ms;
        $display("Simulation FAILED");
        $finish;
    end

    // Both channels are observed at the rising edge. The output is checked
    // before the input is noted; as every result is registered the order does not
    // matter, but it keeps the queue in arrival order either way.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (sub_ch.valid && sub_ch.ready)
                board.check_sub(sub_ch.sub_low, sub_ch.sub_high);
            if (state_ch.valid && state_ch.ready)
                board.note_state(state_ch.state_low, state_ch.state_high);
        end
    end

    // Receiver. Each pass assigns ready once at a falling edge and then moves
    // on by at least one falling edge, so ready is never lowered and raised
    // in the same time step.
    initial
    begin
        sub_ch.ready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (hold_request)
            begin
                // Long hold-off while the sender keeps offering items: the
                // output and skid registers fill and the input must stall.
                hold_request = 1'b0;
                sub_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            else if (sink_stalls && $urandom_range(0, 4) == 0)
            begin
                sub_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(negedge clk);
            end
            else
            begin
                sub_ch.ready <= 1'b1;
                @(negedge clk);
            end
        end
    end

    // Offers one state, starting at a falling edge, and returns at the falling
    // edge after the item has been taken. A gap, when one is drawn, lowers
    // valid at the current edge and raises it again at a later one.
    task automatic offer_state(half_t low_half, half_t high_half);
        if (send_gaps && $urandom_range(0, 4) == 0)
        begin
            state_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        state_ch.valid      <= 1'b1;
        state_ch.state_low  <= low_half;
        state_ch.state_high <= high_half;
        do
            @(posedge clk);
        while (!state_ch.ready);
        @(negedge clk);
    endtask

    // A random state half. Most are uniformly random; the rest are built
    // byte by byte from the all-zero and all-one bytes and random bytes,
    // which puts the extreme bytes next to ordinary ones in every lane.
    function automatic half_t random_half();
        half_t h;
        if ($urandom_range(0, 4) != 0)
            return {$urandom, $urandom};
        for (int k = 0; k < HALF_BYTES; k++)
        begin
            case ($urandom_range(0, 2))
                0: h[k*BYTE_W +: BYTE_W] = 8'h00;
                1: h[k*BYTE_W +: BYTE_W] = 8'hff;
                default: h[k*BYTE_W +: BYTE_W] = byte_t'($urandom);
            endcase
        end
        return h;
    endfunction

    initial
    begin
        half_t low_half;
        half_t high_half;
        int    segment;
        int    wait_cycles;

        rst_n               = 1'b0;
        state_ch.valid      = 1'b0;
        state_ch.state_low  = '0;
        state_ch.state_high = '0;
        send_gaps           = 1'b1;
        sink_stalls         = 1'b1;
        hold_request        = 1'b0;

        // Known S-box images of the bytes 00, 01, 53 and ff, so a slip in the
        // gate network of the predictor shows up even if the block shares it.
        if (subbytes_board::sub_half(64'h00000000_ff530100) !== 64'h63636363_16ed7c63)
        begin
            $display("%0t: predictor self-check failed, expected %h, got %h", $time,
                     64'h63636363_16ed7c63, subbytes_board::sub_half(64'h00000000_ff530100));
            board.errors++;
        end

        repeat (2) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed part: the extreme halves, alternating bit patterns, a
        // one that walks across the lanes, and sixteen states that between them
        // pass every byte value through one of the S-box lanes once.
        offer_state('0, '0);
        offer_state('1, '1);
        offer_state({HALF_BYTES{8'h55}}, {HALF_BYTES{8'haa}});
        offer_state('0, '1);
        offer_state(64'h80402010_08040201, 64'h01020408_10204080);
        for (int j = 0; j < 16; j++)
        begin
            for (int k = 0; k < HALF_BYTES; k++)
            begin
                low_half[k*BYTE_W +: BYTE_W]  = byte_t'(16*j + k);
                high_half[k*BYTE_W +: BYTE_W] = byte_t'(16*j + 8 + k);
            end
            offer_state(low_half, high_half);
        end

        // Random part. Idling on each side is switched in segments of 100
        // items with different patterns, so every mix of gaps and stalls
        // occurs, including stretches with none. The tail runs with no idling
        // so that one item per cycle is offered.
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            segment     = i / 100;
            send_gaps   = (i < RANDOM_ITEMS - CALM_TAIL) && (segment % 3 != 2);
            sink_stalls = (i < RANDOM_ITEMS - CALM_TAIL) && (segment % 4 != 1);
            if (i == 400)
                hold_request = 1'b1;
            offer_state(random_half(), random_half());
        end
        state_ch.valid <= 1'b0;

        // Drain: wait for the outstanding results, then a few more cycles so
        // that a spurious extra result would still be caught.
        wait_cycles = 0;
        while (board.sub_pairs_due.size() != 0 && wait_cycles < DRAIN_LIMIT)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (8) @(posedge clk);

        if (board.sub_pairs_due.size() != 0)
        begin
            $display("%0t: %0d expected results never arrived", $time,
                     board.sub_pairs_due.size());
            board.errors++;
        end

        if (board.errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
